### sv/dpq_pkg.sv
// Package for the double-ended priority queue.
// Holds sizes, the operation codes and the structs passed between cells.
// No dependencies.
package dpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                     en;
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                     occ;
    logic                     gt;
    logic signed [DATA_W-1:0] val;
  } link_t;

endpackage

### sv/dpq_in_if.sv
// Input channel of the queue: one operation word per handshake.
// Depends on nothing.
interface dpq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

### sv/dpq_out_if.sv
// Result channel of the queue: one status word per handshake.
// Depends on nothing.
interface dpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] max_value;
  logic signed [31:0] min_value;
  logic               is_empty;
  logic        [6:0]  entry_count;
  logic               insert_dropped;

  modport source (output valid, output max_value, output min_value, output is_empty,
                  output entry_count, output insert_dropped, input ready);
  modport sink   (input valid, input max_value, input min_value, input is_empty,
                  input entry_count, input insert_dropped, output ready);
endinterface

### sv/double_ended_priority_queue_top.sv
// Double-ended priority queue built as a chain of sorted cells.
// The cells register an accepted operation; the result word loads once the output is free.
// Throughput: one operation per cycle; every cell updates in the accept cycle, and the input
// stalls only while a finished result word waits for the receiver.
// The max is the OR of the cell values, where only the topmost occupied cell passes its value.
// Reset (synchronous, active low) empties the queue; entry values are not cleared.
module double_ended_priority_queue_top (
  input logic     clk,
  input logic     rst_n,
  dpq_in_if.sink  in_ch,
  dpq_out_if.source out_ch
);
  import dpq_pkg::*;

  cmd_t                     cmd;
  link_t                    self_l [CAPACITY];
  link_t                    left_l [CAPACITY];
  link_t                    right_l[CAPACITY];
  logic signed [DATA_W-1:0] top_val[CAPACITY];
  logic signed [DATA_W-1:0] max_or;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             calc_r, calc_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt, min_r, min_nxt;
  logic             empty_r, empty_nxt;
  logic [OUT_CNT_W-1:0] ecount_r, ecount_nxt;
  logic             odrop_r, odrop_nxt;

  logic accept, full, out_free, out_load;
  op_t  op;

  assign op       = op_t'(in_ch.operation);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = calc_r && out_free;
  assign in_ch.ready = !calc_r || out_free;
  assign accept   = in_ch.valid && in_ch.ready;

  assign cmd.en    = accept && !(op == OP_INSERT && full);
  assign cmd.op    = op;
  assign cmd.value = in_ch.value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        // Virtual neighbor below the chain: occupied and never above the value.
        assign left_l[i] = '{occ: 1'b1, gt: 1'b0, val: '0};
      end else begin : g_mid_l
        assign left_l[i] = self_l[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_l[i] = '{occ: 1'b0, gt: 1'b0, val: '0};
      end else begin : g_mid_r
        assign right_l[i] = self_l[i+1];
      end
      dpq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .left_i    (left_l[i]),
        .right_i   (right_l[i]),
        .self_o    (self_l[i]),
        .top_val_o (top_val[i])
      );
    end
  endgenerate

  always_comb begin
    max_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      max_or = max_or | top_val[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (accept) begin
      drop_nxt = (op == OP_INSERT) && full;
      case (op)
        OP_INSERT: begin
          if (!full) count_nxt = count_r + 1'b1;
        end
        OP_DEL_MAX, OP_DEL_MIN: begin
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
        default: begin
          count_nxt = '0;
        end
      endcase
    end
    calc_nxt = accept ? 1'b1 : (out_load ? 1'b0 : calc_r);
  end

  // Result stage reads the chain after the pending operation has settled.
  always_comb begin
    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    max_nxt    = max_r;
    min_nxt    = min_r;
    empty_nxt  = empty_r;
    ecount_nxt = ecount_r;
    odrop_nxt  = odrop_r;
    if (out_load) begin
      max_nxt    = max_or;
      min_nxt    = self_l[0].occ ? self_l[0].val : '0;
      empty_nxt  = (count_r == '0);
      ecount_nxt = OUT_CNT_W'(count_r);
      odrop_nxt  = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      calc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      calc_r      <= calc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r   <= drop_nxt;
    max_r    <= max_nxt;
    min_r    <= min_nxt;
    empty_r  <= empty_nxt;
    ecount_r <= ecount_nxt;
    odrop_r  <= odrop_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.max_value      = max_r;
  assign out_ch.min_value      = min_r;
  assign out_ch.is_empty       = empty_r;
  assign out_ch.entry_count    = ecount_r;
  assign out_ch.insert_dropped = odrop_r;

endmodule

### sv/dpq_cell.sv
// One slot of the sorted chain: holds a value and its occupied flag.
// Depends on dpq_pkg; of the other cells it talks only to its left and right neighbors.
module dpq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  dpq_pkg::cmd_t  cmd,
  input  dpq_pkg::link_t left_i,
  input  dpq_pkg::link_t right_i,
  output dpq_pkg::link_t self_o,
  output logic signed [dpq_pkg::DATA_W-1:0] top_val_o
);
  import dpq_pkg::*;

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     occ_r, occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.en) begin
      case (cmd.op)
        OP_INSERT: begin
          // Entries not above the new value stay; the first slot whose left
          // neighbor is not above it takes the value; the rest shift right.
          occ_nxt = occ_r | left_i.occ;
          if (occ_r && !self_o.gt) begin
            val_nxt = val_r;
          end else if (left_i.occ && !left_i.gt) begin
            val_nxt = cmd.value;
          end else if (left_i.occ) begin
            val_nxt = left_i.val;
          end
        end
        OP_DEL_MAX: begin
          occ_nxt = occ_r & right_i.occ;
        end
        OP_DEL_MIN: begin
          occ_nxt = occ_r & right_i.occ;
          if (right_i.occ) begin
            val_nxt = right_i.val;
          end
        end
        default: begin
          occ_nxt = 1'b0;
        end
      endcase
    end
  end

  assign self_o.occ = occ_r;
  assign self_o.gt  = occ_r && (val_r > cmd.value);
  assign self_o.val = val_r;

  // The highest occupied slot drives its value onto the max bus.
  assign top_val_o = (occ_r && !right_i.occ) ? val_r : '0;

endmodule

### dv/double_ended_priority_queue_top_tb.sv
// Testbench for double_ended_priority_queue_top: drives operation words and checks
// every status word against an in-bench sorted-array predictor.
// Depends on dpq_pkg and the dpq_in_if / dpq_out_if interfaces of the design.
`timescale 1ns / 1ps

module double_ended_priority_queue_top_tb;
  import dpq_pkg::*;

  localparam int LONG_HOLD = 120;
  localparam int DIRECTED_N = 19;
  localparam int RANDOM_N = 380;

  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     insert_dropped;
  } status_t;

  typedef struct packed {
    logic                     drain;
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } op_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpq_in_if  in_ch ();
  dpq_out_if out_ch ();

  double_ended_priority_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: ascending values in slots below shadow_count.
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_count = 0;

  op_word_t op_backlog [$];
  status_t  status_due [$];

  int  error_count = 0;
  int  ops_accepted = 0;
  int  words_checked = 0;
  int  drops_seen = 0;
  int  peak_count = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;

  function automatic status_t queue_after_op(op_t op, logic signed [DATA_W-1:0] v);
    status_t s;
    int      pos;
    s = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          s.insert_dropped = 1'b1;
        end else begin
          pos = shadow_count;
          while (pos > 0 && shadow_entries[pos-1] > v) begin
            shadow_entries[pos] = shadow_entries[pos-1];
            pos--;
          end
          shadow_entries[pos] = v;
          shadow_count++;
        end
      end
      OP_DEL_MAX: begin
        if (shadow_count > 0) shadow_count--;
      end
      OP_DEL_MIN: begin
        if (shadow_count > 0) begin
          for (int i = 0; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: shadow_count = 0;
    endcase
    if (shadow_count > 0) begin
      s.max_value = shadow_entries[shadow_count-1];
      s.min_value = shadow_entries[0];
    end
    s.is_empty = (shadow_count == 0);
    s.entry_count = shadow_count[OUT_CNT_W-1:0];
    return s;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] word %0d: %s got %h, want %h", $realtime, words_checked, field, got, want);
    error_count++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      // A narrow range produces plenty of equal values.
      1, 2, 3: return 32'd8 - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(op_t op, logic signed [DATA_W-1:0] v);
    op_backlog.push_back({1'b0, op, v});
  endtask

  // Sender: holds a word until it is taken, then idles for its drawn gap.
  always @(negedge clk) begin
    op_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (op_backlog.size() != 0 && op_backlog[0].drain) begin
        in_ch.valid <= 1'b0;
        if (status_due.size() == 0) void'(op_backlog.pop_front());
      end else if (op_backlog.size() != 0) begin
        w = op_backlog.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= w.op;
        in_ch.value <= w.value;
        in_gap <= calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: after each word it stalls for a drawn number of cycles.
  always @(negedge clk) begin
    int w;
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (out_taken) begin
      w = calm ? 0 : $urandom_range(0, 3);
      out_wait <= w;
      out_ch.ready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ch.ready <= (out_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted operation and checks every status word.
  always @(posedge clk) begin
    status_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      want = queue_after_op(op_t'(in_ch.operation), in_ch.value);
      status_due.push_back(want);
      ops_accepted++;
      if (shadow_count > peak_count) peak_count = shadow_count;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("unexpected word, max_value", out_ch.max_value, '0);
      end else begin
        want = status_due.pop_front();
        if (out_ch.max_value !== want.max_value)
          report_mismatch("max_value", out_ch.max_value, want.max_value);
        if (out_ch.min_value !== want.min_value)
          report_mismatch("min_value", out_ch.min_value, want.min_value);
        if (out_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_ch.is_empty, want.is_empty);
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_ch.entry_count, want.entry_count);
        if (out_ch.insert_dropped !== want.insert_dropped)
          report_mismatch("insert_dropped", out_ch.insert_dropped, want.insert_dropped);
        if (want.insert_dropped) drops_seen++;
      end
      words_checked++;
    end
  end

  // Alternates stretches of random idling with stretches of none on both sides.
  initial begin
    forever begin
      repeat ($urandom_range(50, 200)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // Long receiver stall while the sender keeps offering words.
  initial begin
    while (ops_accepted < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("double_ended_priority_queue_top verification failed");
    $finish;
  end

  initial begin
    int ins_pct;
    int phase_len;
    int pick;
    int issued;
    bit drain_placed;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    issued = 0;
    drain_placed = 1'b0;

    // Directed: deletes on an empty store, extremes, equal values, ignored value field.
    push_op(OP_DEL_MAX, 32'sh1234_5678);
    push_op(OP_DEL_MIN, -32'sd1);
    push_op(OP_CLEAR, 32'sh0);
    push_op(OP_INSERT, 32'sh0);
    push_op(OP_INSERT, 32'sh7FFF_FFFF);
    push_op(OP_INSERT, 32'sh8000_0000);
    push_op(OP_INSERT, -32'sd1);
    push_op(OP_INSERT, -32'sd1);
    push_op(OP_INSERT, 32'sd1);
    push_op(OP_INSERT, 32'sh5555_5555);
    push_op(OP_INSERT, 32'shAAAA_AAAA);
    push_op(OP_DEL_MAX, 32'shFFFF_FFFF);
    push_op(OP_DEL_MIN, 32'sh0);
    push_op(OP_DEL_MIN, 32'sh7FFF_FFFF);
    push_op(OP_DEL_MAX, 32'sh8000_0000);
    push_op(OP_DEL_MIN, 32'sh0);
    push_op(OP_CLEAR, 32'shFFFF_FFFF);
    push_op(OP_INSERT, -32'sd5);
    push_op(OP_DEL_MAX, 32'sh0);

    // Fill past capacity so that inserts into a full store get dropped.
    for (int i = 0; i < CAPACITY + 6; i++) push_op(OP_INSERT, pick_value());
    issued = CAPACITY + 6;

    // Phases lean toward inserts or deletes, or mix them evenly, so the fill level sweeps its range.
    while (issued < RANDOM_N) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      phase_len = $urandom_range(30, 70);
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) push_op(OP_CLEAR, $urandom);
        else if (pick < 2 + ins_pct) push_op(OP_INSERT, pick_value());
        else if ($urandom_range(0, 1) != 0) push_op(OP_DEL_MAX, $urandom);
        else push_op(OP_DEL_MIN, $urandom);
        issued++;
      end
      if (!drain_placed && issued >= 280) begin
        op_backlog.push_back({1'b1, OP_CLEAR, 32'sh0});
        drain_placed = 1'b1;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_backlog.size() != 0 || in_ch.valid || status_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d operations (%0d directed); %0d status words checked.",
             ops_accepted, DIRECTED_N, words_checked);
    $display("Fill level peaked at %0d of %0d; %0d inserts were dropped on a full store.",
             peak_count, CAPACITY, drops_seen);
    if (error_count == 0) begin
      $display("double_ended_priority_queue_top verification clean");
    end else begin
      $display("double_ended_priority_queue_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/dpq_pkg.sv
sv/dpq_in_if.sv
sv/dpq_out_if.sv
sv/dpq_cell.sv
sv/double_ended_priority_queue_top.sv
dv/double_ended_priority_queue_top_tb.sv
